[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cslt_pkg.sv]
// Package with the types and constants of the checked spot timestamp table.
package cslt_pkg;

  // Default number of table entries.
  localparam int unsigned TableEntriesDef = 64;

  // Field widths.
  localparam int unsigned IdWidth   = 16;
  localparam int unsigned TimeWidth = 32;

  // Opcodes of an input item.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_MARK  = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

[hw/rtl/checked_spot_lru_timestamp_table_unit.sv]
// Top level of the checked spot timestamp table.
// An item accepted with n filled entries waits for a scan of at most n entries, one entry
// per cycle through the single memory read port; the result is registered in the finish state.
// One item at a time; busy is high from acceptance through the finish state and drops
// as the result shows, so the next item can be accepted while the result is shown.
// Reset clears the fill count and the control state; entry contents are not cleared.
module checked_spot_lru_timestamp_table_unit #(
  parameter int unsigned TABLE_ENTRIES = cslt_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [cslt_pkg::IdWidth-1:0]   spot_id_i,
  input  logic [cslt_pkg::TimeWidth-1:0] now_ticks_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [cslt_pkg::TimeWidth-1:0] last_checked_o
);
  import cslt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller.
  cslt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Datapath.
  cslt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .spot_id_i      (spot_id_i),
    .now_ticks_i    (now_ticks_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .last_checked_o (last_checked_o)
  );

endmodule

[hw/rtl/cslt_ctrl.sv]
// Controller state machine of the checked spot timestamp table.
module cslt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  cslt_pkg::status_t status_i,
  output cslt_pkg::cmd_t    cmd_o,
  output logic              busy
);
  import cslt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/cslt_datapath.sv]
// Datapath of the checked spot timestamp table: entry memory, scan and result.
module cslt_datapath #(
  parameter int unsigned TABLE_ENTRIES = cslt_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cslt_pkg::cmd_t                 cmd_i,
  output cslt_pkg::status_t              status_o,
  input  logic                           opcode_i,
  input  logic [cslt_pkg::IdWidth-1:0]   spot_id_i,
  input  logic [cslt_pkg::TimeWidth-1:0] now_ticks_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [cslt_pkg::TimeWidth-1:0] last_checked_o
);
  import cslt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(TABLE_ENTRIES);

  // Entry memory.
  logic [IdWidth-1:0]   id_mem   [TABLE_ENTRIES];
  logic [TimeWidth-1:0] time_mem [TABLE_ENTRIES];

  // Latched item.
  logic                 op_q;
  logic [IdWidth-1:0]   id_q;
  logic [TimeWidth-1:0] now_q;

  // Scan control.
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] cmp_idx_q;
  logic          rd_pend_q, rd_pend_d;
  logic          issue;

  // Read data of the entry under comparison.
  logic [IdWidth-1:0]   rd_id_q;
  logic [TimeWidth-1:0] rd_time_q;

  // Scan results.
  logic                 hit_q, hit_d;
  logic [IW-1:0]        hit_idx_q;
  logic [TimeWidth-1:0] hit_time_q;
  logic [TimeWidth:0]   best_q;
  logic [IW-1:0]        victim_q;
  logic                 cmp_active;
  logic                 cmp_match;
  logic                 cmp_older;

  // Write port.
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  // Result registers.
  logic                 done_q;
  logic                 found_q;
  logic [TimeWidth-1:0] last_q;

  // A read is issued each scan cycle until the filled part is covered or the id is hit.
  assign issue      = cmd_i.scan && !hit_q && (cnt_q != fill_q);
  assign cmp_active = rd_pend_q && !hit_q;
  assign cmp_match  = (rd_id_q == id_q);
  assign cmp_older  = ({1'b0, rd_time_q} < best_q);

  assign status_o.scan_done = !rd_pend_q && (hit_q || (cnt_q == fill_q));

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr]   <= id_q;
      time_mem[wr_addr] <= now_q;
    end
    if (issue) begin
      rd_id_q   <= id_mem[cnt_q[IW-1:0]];
      rd_time_q <= time_mem[cnt_q[IW-1:0]];
      cmp_idx_q <= cnt_q[IW-1:0];
    end
  end

  // Write only for a mark: update in place, append, or replace the oldest entry.
  always_comb begin
    wr_en  = cmd_i.finish && (op_q == OP_MARK);
    fill_d = fill_q;
    if (hit_q) begin
      wr_addr = hit_idx_q;
    end else if (fill_q != FullCount) begin
      wr_addr = fill_q[IW-1:0];
      if (wr_en) fill_d = fill_q + CW'(1);
    end else begin
      wr_addr = victim_q;
    end
  end

  // Next values of the scan control.
  always_comb begin
    cnt_d     = cnt_q;
    rd_pend_d = issue;
    hit_d     = hit_q;
    if (cmd_i.load) begin
      cnt_d = '0;
      hit_d = 1'b0;
    end else begin
      if (issue) cnt_d = cnt_q + CW'(1);
      if (cmp_active && cmp_match) hit_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      hit_q     <= hit_d;
      done_q    <= cmd_i.finish;
    end
  end

  // Item latch, comparison results and the result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      id_q     <= spot_id_i;
      now_q    <= now_ticks_i;
      best_q   <= {1'b0, now_ticks_i} + (TimeWidth + 1)'(1);
      victim_q <= '0;
    end else if (cmp_active) begin
      if (cmp_match) begin
        hit_idx_q  <= cmp_idx_q;
        hit_time_q <= rd_time_q;
      end else if (cmp_older) begin
        best_q   <= {1'b0, rd_time_q};
        victim_q <= cmp_idx_q;
      end
    end
    if (cmd_i.finish) begin
      found_q <= hit_q;
      last_q  <= ((op_q == OP_QUERY) && hit_q) ? hit_time_q : '0;
    end
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign last_checked_o = last_q;

endmodule

[hw/rtl/cslt_checker.sv]
// Port checker of the checked spot timestamp table and its bind.
`include "assert_macros.svh"

module cslt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           opcode_i,
  input logic                           done_o,
  input logic                           found_o,
  input logic [cslt_pkg::TimeWidth-1:0] last_checked_o
);
  import cslt_pkg::*;

  logic last_op_q;

  // Opcode of the item most recently accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_op_q <= OP_QUERY;
    end else if (start && !busy) begin
      last_op_q <= opcode_i;
    end
  end

  `CSLT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy")
  `CSLT_ASSERT_SAME(a_done_idle, done_o, !busy, "Result shown while still busy")
  `CSLT_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "Result strobe held over two cycles")
  `CSLT_ASSERT_SAME(a_miss_zero, done_o && !found_o, last_checked_o == '0, "Miss with timestamp")
  `CSLT_ASSERT_SAME(a_mark_zero, done_o && (last_op_q == OP_MARK), last_checked_o == '0,
                    "Mark result with timestamp")

endmodule

bind checked_spot_lru_timestamp_table_unit cslt_checker u_cslt_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the checked spot timestamp table.
`timescale 1ns / 1ps

module tb;
  import cslt_pkg::*;

  localparam int unsigned Entries = TableEntriesDef;
  localparam int StallLimit = 2000;
  localparam int RandomItems = 1880;
  localparam int CalmTail = 200;
  localparam int DrainCycles = 80;
  localparam int PoolSize = 96;

  // One result item as the block reports it.
  typedef struct packed {
    logic                 found;
    logic [TimeWidth-1:0] last_checked;
  } spot_result_t;

  // One row of the directed stimulus; typed rows carry their own expected result.
  typedef struct packed {
    logic                 op;
    logic [IdWidth-1:0]   id;
    logic [TimeWidth-1:0] now;
    logic                 typed;
    logic                 found;
    logic [TimeWidth-1:0] ts;
  } stim_row_t;

  localparam int DirectedRows = 23;

  stim_row_t directed_rows [DirectedRows] = '{
    // Empty table: every query misses and reads as long ago.
    '{OP_QUERY, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    // Append at the largest time, then update in place at time zero.
    '{OP_MARK,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{OP_MARK,  16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_QUERY, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_MARK,  16'h0000, 32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
    '{OP_QUERY, 16'h0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_MARK,  16'h8000, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'h8000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{OP_MARK,  16'h5555, 32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_MARK,  16'hAAAA, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'h5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'h5555_5555},
    '{OP_QUERY, 16'hAAAA, 32'h5555_5555, 1'b1, 1'b1, 32'hAAAA_AAAA},
    '{OP_MARK,  16'h0000, 32'h0000_0007, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_QUERY, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0007},
    '{OP_QUERY, 16'h7FFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    // A hit whose stored time is zero still reports found.
    '{OP_MARK,  16'h0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'h0001, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_MARK,  16'h1234, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'h1234, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{OP_QUERY, 16'hFFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode_i = OP_QUERY;
  logic [IdWidth-1:0]   spot_id_i = '0;
  logic [TimeWidth-1:0] now_ticks_i = '0;
  logic                 done_o;
  logic                 found_o;
  logic [TimeWidth-1:0] last_checked_o;

  // Shadow copy of the table, kept in step with every accepted item.
  logic [IdWidth-1:0]   shadow_id [Entries];
  logic [TimeWidth-1:0] shadow_time [Entries];
  int unsigned          shadow_fill = 0;

  spot_result_t pending_results [$];
  logic [IdWidth-1:0] id_pool [PoolSize];

  int error_count = 0;
  int items_sent = 0;
  int marks_sent = 0;
  int results_seen = 0;
  int replacements = 0;
  int future_replacements = 0;
  int stall_cycles = 0;

  checked_spot_lru_timestamp_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .spot_id_i      (spot_id_i),
    .now_ticks_i    (now_ticks_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .last_checked_o (last_checked_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Looks the id up in the shadow table and applies a mark, returning the result.
  function automatic spot_result_t lookup_and_mark(input logic op, input logic [IdWidth-1:0] id,
                                                   input logic [TimeWidth-1:0] now);
    spot_result_t res;
    logic [TimeWidth:0] oldest;
    int unsigned victim;
    int hit_index;
    bit none_older;
    res.found = 1'b0;
    res.last_checked = '0;
    hit_index = -1;
    for (int unsigned k = 0; k < shadow_fill; k++) begin
      if (shadow_id[k] == id) begin
        hit_index = k;
        break;
      end
    end
    if (op == OP_QUERY) begin
      if (hit_index >= 0) begin
        res.found = 1'b1;
        res.last_checked = shadow_time[hit_index];
      end
    end else if (hit_index >= 0) begin
      shadow_time[hit_index] = now;
      res.found = 1'b1;
    end else if (shadow_fill < Entries) begin
      shadow_id[shadow_fill] = id;
      shadow_time[shadow_fill] = now;
      shadow_fill++;
    end else begin
      // Full table: the oldest entry below now + 1 goes, the first one on a tie.
      oldest = {1'b0, now} + 1'b1;
      victim = 0;
      none_older = 1'b1;
      for (int unsigned k = 0; k < Entries; k++) begin
        if ({1'b0, shadow_time[k]} < oldest) begin
          oldest = {1'b0, shadow_time[k]};
          victim = k;
          none_older = 1'b0;
        end
      end
      shadow_id[victim] = id;
      shadow_time[victim] = now;
      replacements++;
      if (none_older) future_replacements++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic op, input logic [IdWidth-1:0] id,
                           input logic [TimeWidth-1:0] now, input logic typed,
                           input spot_result_t typed_result);
    spot_result_t predicted;
    opcode_i <= op;
    spot_id_i <= id;
    now_ticks_i <= now;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predicted = lookup_and_mark(op, id, now);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
    if (op == OP_MARK) marks_sent++;
  endtask

  // Sender idles for a burst, optionally only once the block has gone idle.
  task automatic idle_burst(input int cycles, input bit after_busy);
    start <= 1'b0;
    @(posedge clk_i);
    while (after_busy && busy) @(posedge clk_i);
    repeat (cycles - 1) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    spot_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found)
          report_mismatch($sformatf("found %b, expected %b", found_o, want.found));
        if (last_checked_o !== want.last_checked)
          report_mismatch($sformatf("last_checked %h, expected %h",
                                    last_checked_o, want.last_checked));
      end
    end
  end

  // Watchdog on cycles in which neither an item nor a result moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("[%0t] Watchdog expired with %0d results outstanding",
                 $realtime, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus: reset, directed rows, then random traffic with idling and pauses.
  initial begin
    spot_result_t row_result;
    spot_result_t no_result;
    logic op;
    logic [IdWidth-1:0] id;
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] clock_ticks;
    int pick;
    bit idle_on;
    no_result = '0;
    clock_ticks = 32'd1000;
    idle_on = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int p = 2; p < PoolSize; p++) id_pool[p] = IdWidth'($urandom_range(0, 65535));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row_result.found = directed_rows[r].found;
      row_result.last_checked = directed_rows[r].ts;
      send_item(directed_rows[r].op, directed_rows[r].id, directed_rows[r].now,
                directed_rows[r].typed, row_result);
    end
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) idle_on = (i < RandomItems - CalmTail) && ($urandom_range(0, 2) != 0);
      if (i % 250 == 125) begin
        drain_results();
      end else if (idle_on && $urandom_range(0, 9) < 3) begin
        idle_burst($urandom_range(1, 4), $urandom_range(0, 1));
      end

      op = $urandom_range(0, 1) ? OP_MARK : OP_QUERY;
      id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, PoolSize - 1)]
                                       : IdWidth'($urandom_range(0, 65535));
      // Mostly a rising clock; sometimes times far off, at the extremes, or bunched for ties.
      clock_ticks += $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 65)      now = clock_ticks;
      else if (pick < 77) now = $urandom();
      else if (pick < 84) now = '0;
      else if (pick < 90) now = '1;
      else                now = $urandom_range(0, 3);
      send_item(op, id, now, 1'b0, no_result);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d items (%0d marks), %0d results checked, table filled to %0d.",
             items_sent, marks_sent, results_seen, shadow_fill);
    $display("Full-table replacements: %0d, of which %0d with every entry in the future.",
             replacements, future_replacements);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
